[hdl/overlap_add_accumulate_normalize_core_defines.svh]
// Assertion macros shared by the RTL files.
`ifndef OVERLAP_ADD_ACCUMULATE_NORMALIZE_CORE_DEFINES_SVH
`define OVERLAP_ADD_ACCUMULATE_NORMALIZE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OAAN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define OAAN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define OAAN_ASSERT(lbl, prop, msg)
`define OAAN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hdl/oaan_pkg.sv]
package oaan_pkg;
  localparam int unsigned FrameSize = 1024;
  localparam int unsigned IdxW = $clog2(FrameSize);
  localparam logic [1:0] OpAcc = 2'd0;
  localparam logic [1:0] OpWin = 2'd1;
  localparam logic [1:0] OpNorm = 2'd2;
  localparam logic [1:0] OpNop = 2'd3;
  localparam int unsigned DivSteps = 41;

  typedef struct packed {
    logic neg;
    logic [IdxW-1:0] idx;
    logic [16:0] dvs;
  } div_ctl_t;
endpackage

[hdl/overlap_add_accumulate_normalize_core.sv]
`include "overlap_add_accumulate_normalize_core_defines.svh"
// Weighted overlap-add engine: each beat adds sample*gain (op 0) or
// sample*window*gain (op 1) into a 1024-entry Q8.24 accumulator, or (op 2)
// emits entry*256/max(norm, norm_floor), rounded and saturated, then clears
// the entry. Ops 3 and indexes past the frame do nothing. Throughput is one
// beat per cycle while no result waits at the output and no clearing pass
// runs; a result passes three front stages, the 41-stage radix-2 divider
// and the output register. After reset the core runs a clearing pass over
// all 1024 entries (one entry a cycle) before taking beats; norm_floor
// should be written only while no beat is in flight. Back-to-back hits on
// the same entry are served by forwarding from the write-back stage. The
// whole pipeline stalls only when a result waits at the output.
module overlap_add_accumulate_normalize_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [9:0] index_i,
  input  logic signed [15:0] sample_i,
  input  logic [15:0] window_i,
  input  logic signed [15:0] gain_i,
  input  logic [15:0] norm_i,
  input  logic cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [31:0] value_o,
  output logic [9:0] out_index_o
);
  localparam int unsigned AW = oaan_pkg::IdxW;

  logic [15:0] floor_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= 16'd1;
    end else if (cfg_we_i) begin
      floor_q <= (cfg_wdata_i == 16'd0) ? 16'd1 : cfg_wdata_i;
    end
  end

  // Clearing pass.
  logic [AW:0] clr_q;
  logic clr_busy;
  assign clr_busy = !clr_q[AW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Output register; whole pipe advances when it can accept.
  logic ov_q, en;
  logic dv;
  logic [31:0] dval;
  logic [AW-1:0] didx;
  assign en = !ov_q || out_ready_i;
  assign in_ready_o = en && !clr_busy;
  logic acc_in;
  assign acc_in = in_valid_i && in_ready_o;

  // Stage 1: register the beat.
  logic v1_q;
  logic [1:0] op1_q;
  logic [AW-1:0] i1_q;
  logic signed [15:0] s1_q, g1_q;
  logic [15:0] w1_q, n1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc_in && opcode_i != oaan_pkg::OpNop;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= opcode_i; i1_q <= index_i; s1_q <= sample_i;
      g1_q <= gain_i; w1_q <= window_i; n1_q <= norm_i;
    end
  end

  // Stage 2: sample*gain, window copy, divisor.
  logic v2_q;
  logic [1:0] op2_q;
  logic [AW-1:0] i2_q;
  logic signed [31:0] p2_q;
  logic [15:0] w2_q;
  logic [16:0] d2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q <= op1_q; i2_q <= i1_q; w2_q <= w1_q;
      p2_q <= s1_q * g1_q;
      d2_q <= {1'b0, (n1_q > floor_q) ? n1_q : floor_q};
    end
  end

  // Stage 3: apply window, form rounded term; memory read issued.
  logic [31:0] mem [oaan_pkg::FrameSize];
  logic v3_q;
  logic [1:0] op3_q;
  logic [AW-1:0] i3_q;
  logic signed [32:0] t3_q;
  logic [16:0] d3_q;
  logic signed [48:0] wp;
  logic signed [48:0] tw;
  logic signed [32:0] tp;
  always_comb begin
    wp = p2_q * $signed({1'b0, w2_q});
    tw = (wp + 49'sd131072) >>> 18;
    tp = 33'((p2_q + 32'sd4) >>> 3);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op3_q <= op2_q; i3_q <= i2_q; d3_q <= d2_q;
      t3_q <= (op2_q == oaan_pkg::OpWin) ? 33'(tw) : tp;
    end
  end

  // Stage 4: accumulate with forwarding, write back.
  logic v4_q;
  logic [AW-1:0] i4_q;
  logic [31:0] w4_q;
  logic [31:0] old;
  logic signed [33:0] sum;
  logic [31:0] nv;
  logic [31:0] rd_q;
  always_comb begin
    old = (v4_q && i4_q == i3_q) ? w4_q : rd_q;
    sum = $signed({{2{old[31]}}, old}) + $signed({t3_q[32], t3_q});
    if (sum > 34'sh7FFFFFFF) nv = 32'h7FFFFFFF;
    else if (sum < -34'sh80000000) nv = 32'h80000000;
    else nv = sum[31:0];
    if (op3_q == oaan_pkg::OpNorm) nv = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en || clr_busy) begin
      v4_q <= en && v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem[clr_q[AW-1:0]] <= '0;
    end else if (en && v3_q) begin
      mem[i3_q] <= nv;
    end
    if (en) begin
      i4_q <= i3_q; w4_q <= nv;
      // Read for the beat entering stage 3.
      rd_q <= mem[i2_q];
    end
  end

  // Divider feed: magnitude of the old entry times 256.
  logic [31:0] mg;
  logic [40:0] mag;
  oaan_pkg::div_ctl_t dctl;
  always_comb begin
    mg = old[31] ? 32'(-old) : old;
    mag = {1'b0, mg, 8'd0};
    dctl.neg = old[31];
    dctl.idx = i3_q;
    dctl.dvs = d3_q;
  end

  oaan_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(en && v3_q && op3_q == oaan_pkg::OpNorm),
    .mag_i(mag), .ctl_i(dctl),
    .vld_o(dv), .val_o(dval), .idx_o(didx)
  );

  logic [31:0] val_q;
  logic [AW-1:0] oi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= dval; oi_q <= didx;
    end
  end
  assign out_valid_o = ov_q;
  assign value_o = val_q;
  assign out_index_o = oi_q;

  `OAAN_ASSERT(a_no_in_clr, !(clr_busy && in_ready_o), "beat taken during clear")
  `OAAN_ASSERT_NEXT(a_out_hold, ov_q && !out_ready_i, ov_q && $stable(val_q),
    "result lost while stalled")
  `OAAN_ASSERT(a_floor, floor_q != 16'd0, "zero floor")
endmodule

[hdl/oaan_div.sv]
`include "overlap_add_accumulate_normalize_core_defines.svh"
// Pipelined restoring divider, one quotient bit per stage, rounding and
// saturation on the output of the last stage. Stalls freeze every stage.
module oaan_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  logic [40:0] mag_i,
  input  oaan_pkg::div_ctl_t ctl_i,
  output logic vld_o,
  output logic [31:0] val_o,
  output logic [oaan_pkg::IdxW-1:0] idx_o
);
  localparam int unsigned N = oaan_pkg::DivSteps;
  logic [N:0] vld_q;
  logic [40:0] num_q [N+1];
  logic [16:0] rem_q [N+1];
  logic [40:0] quo_q [N+1];
  oaan_pkg::div_ctl_t ctl_q [N+1];

  always_comb begin
    vld_q[0] = vld_i;
    num_q[0] = mag_i;
    rem_q[0] = '0;
    quo_q[0] = '0;
    ctl_q[0] = ctl_i;
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [17:0] tr;
    logic [17:0] df;
    always_comb begin
      tr = {rem_q[s], num_q[s][40]};
      df = tr - {1'b0, ctl_q[s].dvs};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= {num_q[s][39:0], 1'b0};
        ctl_q[s+1] <= ctl_q[s];
        if (!df[17]) begin
          rem_q[s+1] <= df[16:0];
          quo_q[s+1] <= {quo_q[s][39:0], 1'b1};
        end else begin
          rem_q[s+1] <= tr[16:0];
          quo_q[s+1] <= {quo_q[s][39:0], 1'b0};
        end
      end
    end
  end

  // Round half away from zero: 2*rem >= dvs, then saturate.
  logic up;
  logic [41:0] q;
  logic [31:0] pos;
  always_comb begin
    up = ({rem_q[N], 1'b0} >= {1'b0, ctl_q[N].dvs});
    q = {1'b0, quo_q[N]} + {41'd0, up};
    if (ctl_q[N].neg) begin
      pos = (q > 42'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
    end else begin
      pos = (q > 42'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    end
  end
  assign vld_o = vld_q[N];
  assign val_o = pos;
  assign idx_o = ctl_q[N].idx;

  `OAAN_ASSERT(a_dvs_nz, !vld_q[N] || ctl_q[N].dvs != 17'd0, "zero divisor")
  `OAAN_ASSERT_NEXT(a_hold, !en_i, $stable(vld_q[N:1]), "stalled divider moved")
  `OAAN_ASSERT(a_rem, !vld_q[N] || rem_q[N] < ctl_q[N].dvs, "remainder too large")
endmodule

[bench/tb_overlap_add_accumulate_normalize_core.sv]
module tb_overlap_add_accumulate_normalize_core;

  // Scoreboard: mirrors the accumulator and divisor floor, and keeps the
  // normalized values still owed by the block.
  class oaan_scoreboard;
    logic signed [31:0] acc_mirror [oaan_pkg::FrameSize];
    logic [15:0] floor_q88;
    logic signed [31:0] owed_value [$];
    logic [9:0] owed_index [$];
    int unsigned mismatches;

    function void wipe();
      foreach (acc_mirror[i]) acc_mirror[i] = '0;
      floor_q88 = 16'd1;
      mismatches = 0;
    endfunction

    function void set_floor(logic [15:0] v);
      floor_q88 = (v == 16'd0) ? 16'd1 : v;
    endfunction

    static function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Round half toward plus infinity; arithmetic shift floors, so this is exact.
    static function longint round_up_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void note_beat(logic [1:0] op, logic [9:0] idx, logic signed [15:0] smp,
                            logic [15:0] win, logic signed [15:0] gn, logic [15:0] nrm);
      longint term, entry, quo;
      longint unsigned mag, dv;
      if (idx >= oaan_pkg::FrameSize) return;
      entry = acc_mirror[idx];
      if (op == oaan_pkg::OpAcc || op == oaan_pkg::OpWin) begin
        if (op == oaan_pkg::OpAcc) term = round_up_shift(longint'(smp) * longint'(gn), 3);
        else term = round_up_shift(longint'(smp) * longint'({1'b0, win}) * longint'(gn), 18);
        acc_mirror[idx] = clip32(entry + term);
      end else if (op == oaan_pkg::OpNorm) begin
        dv = (nrm > floor_q88) ? nrm : floor_q88;
        mag = (entry < 0 ? -entry : entry) << 8;
        quo = longint'((mag + dv / 2) / dv);
        owed_value.push_back(clip32(entry < 0 ? -quo : quo));
        owed_index.push_back(idx);
        acc_mirror[idx] = '0;
      end
    endfunction

    function void check_result(logic signed [31:0] val, logic [9:0] idx);
      logic signed [31:0] ev;
      logic [9:0] ei;
      if (owed_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d index=%0d", val, idx);
        return;
      end
      ev = owed_value.pop_front();
      ei = owed_index.pop_front();
      if (val !== ev || idx !== ei) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value exp %0d got %0d, index exp %0d got %0d", ev, val, ei, idx);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] opcode_i;
  logic [9:0] index_i;
  logic signed [15:0] sample_i;
  logic [15:0] window_i;
  logic signed [15:0] gain_i;
  logic [15:0] norm_i;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [31:0] value_o;
  logic [9:0] out_index_o;

  oaan_scoreboard board;
  int unsigned results_seen;
  // Raised while the receiver is allowed to stall; lowered for stretches of full flow.
  bit stall_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  overlap_add_accumulate_normalize_core DUT (.*);

  // Receiver: stalls on its own pattern, checks every accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_result(value_o, out_index_o);
        results_seen++;
      end
      out_ready_i <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Sends one beat: valid rises at an edge and stays until the handshake.
  task automatic send_beat(logic [1:0] op, logic [9:0] idx, logic [15:0] smp,
                           logic [15:0] win, logic [15:0] gn, logic [15:0] nrm);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    index_i <= idx;
    sample_i <= smp;
    window_i <= win;
    gain_i <= gn;
    norm_i <= nrm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_beat(op, idx, smp, win, gn, nrm);
  endtask

  // Ends a burst: valid drops for a random gap.
  task automatic pause_sender(int gap);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // The floor is only rewritten with the pipeline drained, so the divider
  // cannot be holding an item when the new divisor floor lands.
  task automatic write_floor(logic [15:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed_value.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_floor(v);
  endtask

  // Random window stays in its legal range of 0 to 1.0 in Q1.15.
  function automatic logic [15:0] rand_window();
    return ($urandom_range(0, 9) == 0) ? 16'h8000 : 16'($urandom_range(0, 32768));
  endfunction

  // Random bursts on a small span of entries: mostly accumulates of both
  // kinds, with occasional normalizes and no-ops, and random pauses between.
  task automatic random_phase(int beats, int idx_span);
    int sent;
    int burst;
    logic [9:0] base;
    logic [9:0] idx;
    logic [1:0] op;
    sent = 0;
    while (sent < beats) begin
      burst = $urandom_range(1, 12);
      base = 10'($urandom);
      repeat (burst) begin
        idx = 10'(base + $urandom_range(0, idx_span));
        op = ($urandom_range(0, 5) == 0) ? oaan_pkg::OpNorm :
             ($urandom_range(0, 1) ? oaan_pkg::OpAcc : oaan_pkg::OpWin);
        if ($urandom_range(0, 30) == 0) op = oaan_pkg::OpNop;
        send_beat(op, idx, 16'($urandom), rand_window(), 16'($urandom), 16'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    board = new();
    board.wipe();
    results_seen = 0;
    stall_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = oaan_pkg::OpAcc;
    index_i = '0;
    sample_i = '0;
    window_i = '0;
    gain_i = '0;
    norm_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every opcode, opcode 3, reset floor of 1,
    // positive saturation of the result, and back-to-back hits on one entry.
    send_beat(oaan_pkg::OpAcc, 10'd0, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
    send_beat(oaan_pkg::OpAcc, 10'd0, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
    send_beat(oaan_pkg::OpNorm, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(oaan_pkg::OpWin, 10'd1023, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    send_beat(oaan_pkg::OpWin, 10'd1023, 16'h8000, 16'h8000, 16'h7fff, 16'hffff);
    send_beat(oaan_pkg::OpWin, 10'd1023, 16'h8000, 16'h8000, 16'h7fff, 16'hffff);
    send_beat(oaan_pkg::OpNorm, 10'd1023, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(oaan_pkg::OpNop, 10'd5, 16'h7fff, 16'h8000, 16'h7fff, 16'h0100);
    send_beat(oaan_pkg::OpNorm, 10'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
    send_beat(oaan_pkg::OpAcc, 10'd7, 16'h0001, 16'h0000, 16'h0001, 16'h0000);
    send_beat(oaan_pkg::OpAcc, 10'd8, 16'hffff, 16'h0000, 16'h0003, 16'h0000);
    send_beat(oaan_pkg::OpWin, 10'd8, 16'h0001, 16'h0001, 16'h0001, 16'h0000);
    send_beat(oaan_pkg::OpNorm, 10'd7, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
    send_beat(oaan_pkg::OpNorm, 10'd8, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
    send_beat(oaan_pkg::OpNorm, 10'd8, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int k = 0; k < 6; k++)
      send_beat(oaan_pkg::OpAcc, 10'd9, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_beat(oaan_pkg::OpNorm, 10'd9, 16'h0000, 16'h0000, 16'h0000, 16'h0001);

    // Random phases over several floor settings, the extremes among them;
    // a zero write must behave as a floor of one.
    stall_on = 1'b1;
    random_phase(300, 7);
    write_floor(16'hffff);
    random_phase(300, 3);
    write_floor(16'h0000);
    stall_on = 1'b0;
    random_phase(250, 15);
    stall_on = 1'b1;
    write_floor(16'h0100);
    random_phase(300, 7);
    write_floor(16'h5a5a);
    random_phase(250, 1);
    write_floor(16'h0001);
    random_phase(300, 7);

    while (board.owed_value.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered ~1720 beats of all opcodes over six floor settings, %0d results checked",
             results_seen);
    if (board.mismatches == 0 && board.owed_value.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog sized well above the clearing pass plus a fully stalled run.
  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("status: fail");
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/oaan_pkg.sv
hdl/oaan_div.sv
hdl/overlap_add_accumulate_normalize_core.sv
bench/tb_overlap_add_accumulate_normalize_core.sv
